// ===== rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg: shared definitions for the barycentric point-in-triangle block
// Register index codes of the configuration port and the flag bundle that
// travels beside the weights through the division pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C_Y = 3'd5;

  // Per-point status that rides along with the partial quotients.
  typedef struct packed {
    logic in_tri;
    logic degen;
    logic neg_a;
    logic sat_a;
    logic neg_b;
    logic sat_b;
  } bpt_flags_t;

endpackage

// ===== rtl/bpt_if.sv =====
// ----------------------------------------------------------------------------
// bpt_if: valid/ready channels of the barycentric point-in-triangle block
// The point channel carries one test point per beat, the result channel the
// inside flag, the three weights and the degenerate flag.
// ----------------------------------------------------------------------------
interface bpt_point_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface bpt_result_if #(
  parameter int WEIGHT_FRAC_BITS = 16
) ();
  logic                                 valid;
  logic                                 ready;
  logic                                 inside_res;
  logic signed [WEIGHT_FRAC_BITS+1:0]   weight_a;
  logic signed [WEIGHT_FRAC_BITS+1:0]   weight_b;
  logic signed [WEIGHT_FRAC_BITS+1:0]   weight_c;
  logic                                 degenerate;

  modport source (output valid, output inside_res, output weight_a, output weight_b,
                  output weight_c, output degenerate, input ready);
  modport sink (input valid, input inside_res, input weight_a, input weight_b,
                input weight_c, input degenerate, output ready);
endinterface

// ===== rtl/barycentric_point_in_triangle_top.sv =====
// ----------------------------------------------------------------------------
// barycentric_point_in_triangle_top: 2D barycentric point-in-triangle test
// Computes fixed-point barycentric weights of a point against a configured
// triangle and reports whether the point lies in or on the triangle.
// ----------------------------------------------------------------------------
// The block takes one point per clock unless the pipeline is stalled, and
// returns one result beat per point, in order. Six front stages form the
// edge numerators and the exact inside test, a WEIGHT_FRAC_BITS-deep
// divider pipeline produces one quotient bit per stage for both weights,
// and two back stages apply sign, saturation and the third weight. Every
// stage holds its beat on its own, so a stalled result channel does not
// block points from entering until the pipeline is full. The user must
// write the triangle's vertices through the configuration port only while
// no point is in flight; the block does not enforce this. The area
// denominator is derived from the vertices in a four-stage side pipeline
// that keeps up with a point accepted on the very next cycle. All vertices
// reset to zero, which is a degenerate triangle.
module barycentric_point_in_triangle_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]          cfg_data_i,
  bpt_point_if.sink                       pt_i,
  bpt_result_if.source                    res_o
);

  // Coordinate differences, products, full sums and the numerator width.
  // Above 30-bit coordinates the numerators wrap at 64 bits.
  localparam int W  = COORD_WIDTH;
  localparam int F  = WEIGHT_FRAC_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 4;
  localparam int NW = (SW > 64) ? 64 : SW;
  localparam int WW = F + 2;
  localparam int CW = WW + 2;

  localparam logic [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};
  localparam logic [CW-1:0] C_MAX = {3'b000, {(WW-1){1'b1}}};
  localparam logic [CW-1:0] C_MIN = {3'b111, {(WW-1){1'b0}}};
  localparam logic [CW-1:0] C_ONE = {3'b000, 1'b1, {F{1'b0}}};

  // True when n lies in [0, d] as signed values.
  function automatic logic in_unit(input logic [NW-1:0] n, input logic [NW-1:0] d);
    return !n[NW-1] && ($signed(n) <= $signed(d));
  endfunction

  // --------------------------------------------------------------------------
  // Vertex registers.
  // --------------------------------------------------------------------------
  logic [W-1:0] va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_x_q <= '0;
      va_y_q <= '0;
      vb_x_q <= '0;
      vb_y_q <= '0;
      vc_x_q <= '0;
      vc_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpt_pkg::REG_A_X: va_x_q <= cfg_data_i;
        bpt_pkg::REG_A_Y: va_y_q <= cfg_data_i;
        bpt_pkg::REG_B_X: vb_x_q <= cfg_data_i;
        bpt_pkg::REG_B_Y: vb_y_q <= cfg_data_i;
        bpt_pkg::REG_C_X: vc_x_q <= cfg_data_i;
        bpt_pkg::REG_C_Y: vc_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Triangle side pipeline: edge differences, area products, area sum and its
  // sign-normalized magnitude. These run every cycle from the vertex registers.
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] dbc_y_q, dcb_x_q, dca_y_q, dac_x_q, dac_y_q;
  logic signed [PW-1:0] den_p0_q, den_p1_q;
  logic signed [SW-1:0] den_sum;
  logic [NW-1:0]        den_q;
  logic [NW-1:0]        den_norm_q;
  logic                 den_neg_q;
  logic                 den_zero_q;

  assign den_sum = SW'(den_p0_q) + SW'(den_p1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_y_q    <= '0;
      dcb_x_q    <= '0;
      dca_y_q    <= '0;
      dac_x_q    <= '0;
      dac_y_q    <= '0;
      den_p0_q   <= '0;
      den_p1_q   <= '0;
      den_q      <= '0;
      den_norm_q <= '0;
      den_neg_q  <= 1'b0;
      den_zero_q <= 1'b1;
    end else begin
      dbc_y_q    <= {vb_y_q[W-1], vb_y_q} - {vc_y_q[W-1], vc_y_q};
      dcb_x_q    <= {vc_x_q[W-1], vc_x_q} - {vb_x_q[W-1], vb_x_q};
      dca_y_q    <= {vc_y_q[W-1], vc_y_q} - {va_y_q[W-1], va_y_q};
      dac_x_q    <= {va_x_q[W-1], va_x_q} - {vc_x_q[W-1], vc_x_q};
      dac_y_q    <= {va_y_q[W-1], va_y_q} - {vc_y_q[W-1], vc_y_q};
      den_p0_q   <= dbc_y_q * dac_x_q;
      den_p1_q   <= dcb_x_q * dac_y_q;
      den_q      <= den_sum[NW-1:0];
      den_neg_q  <= den_q[NW-1];
      den_zero_q <= (den_q == '0);
      den_norm_q <= den_q[NW-1] ? -den_q : den_q;
    end
  end

  // --------------------------------------------------------------------------
  // Point pipeline, stages 1 to 6. Each stage loads when it is empty or when
  // the stage after it takes its beat.
  // --------------------------------------------------------------------------
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_t1, rdy_t2;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, t1_v_q, out_v_q;
  logic div_in_ready, div_out_valid;

  assign rdy_t2    = !out_v_q || res_o.ready;
  assign rdy_t1    = !t1_v_q || rdy_t2;
  assign rdy6      = !v6_q || div_in_ready;
  assign rdy5      = !v5_q || rdy6;
  assign rdy4      = !v4_q || rdy5;
  assign rdy3      = !v3_q || rdy4;
  assign rdy2      = !v2_q || rdy3;
  assign rdy1      = !v1_q || rdy2;
  assign pt_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      t1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)   v1_q    <= pt_i.valid;
      if (rdy2)   v2_q    <= v1_q;
      if (rdy3)   v3_q    <= v2_q;
      if (rdy4)   v4_q    <= v3_q;
      if (rdy5)   v5_q    <= v4_q;
      if (rdy6)   v6_q    <= v5_q;
      if (rdy_t1) t1_v_q  <= div_out_valid;
      if (rdy_t2) out_v_q <= t1_v_q;
    end
  end

  // Stage 1: point relative to vertex C.
  logic signed [DW-1:0] dpx_q, dpy_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      dpx_q <= {pt_i.point_x[W-1], pt_i.point_x} - {vc_x_q[W-1], vc_x_q};
      dpy_q <= {pt_i.point_y[W-1], pt_i.point_y} - {vc_y_q[W-1], vc_y_q};
    end
  end

  // Stage 2: the four numerator products.
  logic signed [PW-1:0] pa0_q, pa1_q, pb0_q, pb1_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pa0_q <= dbc_y_q * dpx_q;
      pa1_q <= dcb_x_q * dpy_q;
      pb0_q <= dca_y_q * dpx_q;
      pb1_q <= dac_x_q * dpy_q;
    end
  end

  // Stage 3: numerators of weights A and B.
  logic signed [SW-1:0] na_sum, nb_sum;
  logic [NW-1:0]        na3_q, nb3_q;

  assign na_sum = SW'(pa0_q) + SW'(pa1_q);
  assign nb_sum = SW'(pb0_q) + SW'(pb1_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      na3_q <= na_sum[NW-1:0];
      nb3_q <= nb_sum[NW-1:0];
    end
  end

  // Stage 4: numerator of weight C is what the area leaves over.
  logic [NW-1:0] na4_q, nb4_q, nc4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      na4_q <= na3_q;
      nb4_q <= nb3_q;
      nc4_q <= den_q - na3_q - nb3_q;
    end
  end

  // Stage 5: numerators flipped to a positive area for the inside test, and
  // magnitudes plus quotient signs for the divider.
  logic [NW-1:0] na_neg, nb_neg;
  logic [NW-1:0] sa5_q, sb5_q, sc5_q, ma5_q, mb5_q;
  logic          nega5_q, negb5_q;

  assign na_neg = -na4_q;
  assign nb_neg = -nb4_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      sa5_q   <= den_neg_q ? na_neg : na4_q;
      sb5_q   <= den_neg_q ? nb_neg : nb4_q;
      sc5_q   <= den_neg_q ? -nc4_q : nc4_q;
      ma5_q   <= na4_q[NW-1] ? na_neg : na4_q;
      mb5_q   <= nb4_q[NW-1] ? nb_neg : nb4_q;
      nega5_q <= na4_q[NW-1] ^ den_neg_q;
      negb5_q <= nb4_q[NW-1] ^ den_neg_q;
    end
  end

  // Stage 6: exact inside test, integer part of each quotient and the first
  // remainder. An integer part of two or more saturates the weight.
  logic                ge_a, ge_b;
  logic [NW-1:0]       ra6_q, rb6_q;
  logic                ipa6_q, ipb6_q;
  bpt_pkg::bpt_flags_t flags6_q;

  assign ge_a = (ma5_q >= den_norm_q);
  assign ge_b = (mb5_q >= den_norm_q);

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      ra6_q           <= ge_a ? (ma5_q - den_norm_q) : ma5_q;
      rb6_q           <= ge_b ? (mb5_q - den_norm_q) : mb5_q;
      ipa6_q          <= ge_a;
      ipb6_q          <= ge_b;
      flags6_q.in_tri <= in_unit(sa5_q, den_norm_q) && in_unit(sb5_q, den_norm_q) &&
                         in_unit(sc5_q, den_norm_q);
      flags6_q.degen  <= den_zero_q;
      flags6_q.neg_a  <= nega5_q;
      flags6_q.neg_b  <= negb5_q;
      flags6_q.sat_a  <= ({1'b0, ma5_q} >= {den_norm_q, 1'b0});
      flags6_q.sat_b  <= ({1'b0, mb5_q} >= {den_norm_q, 1'b0});
    end
  end

  // --------------------------------------------------------------------------
  // Fraction bits of both weights.
  // --------------------------------------------------------------------------
  logic [F:0]          qa_div, qb_div;
  bpt_pkg::bpt_flags_t flags_div;

  bpt_div #(
    .NW (NW),
    .F  (F)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .in_ready_o  (div_in_ready),
    .in_ra_i     (ra6_q),
    .in_rb_i     (rb6_q),
    .in_qa_i     (ipa6_q),
    .in_qb_i     (ipb6_q),
    .in_flags_i  (flags6_q),
    .dm_i        (den_norm_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_t1),
    .out_qa_o    (qa_div),
    .out_qb_o    (qb_div),
    .out_flags_o (flags_div)
  );

  // --------------------------------------------------------------------------
  // Back stage 1: signed, saturated weights A and B.
  // --------------------------------------------------------------------------
  logic [WW-1:0]       qa_ext, qb_ext;
  logic [WW-1:0]       wa_q, wb_q;
  bpt_pkg::bpt_flags_t t1_flags_q;

  assign qa_ext = {1'b0, qa_div};
  assign qb_ext = {1'b0, qb_div};

  always_ff @(posedge clk_i) begin
    if (rdy_t1) begin
      if (flags_div.sat_a) begin
        wa_q <= flags_div.neg_a ? W_MIN : W_MAX;
      end else begin
        wa_q <= flags_div.neg_a ? -qa_ext : qa_ext;
      end
      if (flags_div.sat_b) begin
        wb_q <= flags_div.neg_b ? W_MIN : W_MAX;
      end else begin
        wb_q <= flags_div.neg_b ? -qb_ext : qb_ext;
      end
      t1_flags_q <= flags_div;
    end
  end

  // --------------------------------------------------------------------------
  // Back stage 2 (output register): weight C as one minus the truncated weights,
  // saturated. A degenerate triangle clears everything but its own flag.
  // --------------------------------------------------------------------------
  logic [CW-1:0] wc_full;
  logic [WW-1:0] wc_sat;

  assign wc_full = C_ONE - {{2{wa_q[WW-1]}}, wa_q} - {{2{wb_q[WW-1]}}, wb_q};

  always_comb begin
    if ($signed(wc_full) > $signed(C_MAX)) begin
      wc_sat = W_MAX;
    end else if ($signed(wc_full) < $signed(C_MIN)) begin
      wc_sat = W_MIN;
    end else begin
      wc_sat = wc_full[WW-1:0];
    end
  end

  logic          inside_q, degen_q;
  logic [WW-1:0] wa_out_q, wb_out_q, wc_out_q;

  always_ff @(posedge clk_i) begin
    if (rdy_t2) begin
      degen_q <= t1_flags_q.degen;
      if (t1_flags_q.degen) begin
        inside_q <= 1'b0;
        wa_out_q <= '0;
        wb_out_q <= '0;
        wc_out_q <= '0;
      end else begin
        inside_q <= t1_flags_q.in_tri;
        wa_out_q <= wa_q;
        wb_out_q <= wb_q;
        wc_out_q <= wc_sat;
      end
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.inside_res = inside_q;
  assign res_o.weight_a   = wa_out_q;
  assign res_o.weight_b   = wb_out_q;
  assign res_o.weight_c   = wc_out_q;
  assign res_o.degenerate = degen_q;

endmodule

// ===== rtl/bpt_div.sv =====
// ----------------------------------------------------------------------------
// bpt_div: pipelined restoring divider for two fractions
// One quotient bit per stage for both weights; each stage holds its beat
// until the next stage can take it.
// ----------------------------------------------------------------------------
module bpt_div #(
  parameter int NW = 36,
  parameter int F  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NW-1:0]       in_ra_i,
  input  logic [NW-1:0]       in_rb_i,
  input  logic                in_qa_i,
  input  logic                in_qb_i,
  input  bpt_pkg::bpt_flags_t in_flags_i,
  input  logic [NW-1:0]       dm_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [F:0]          out_qa_o,
  output logic [F:0]          out_qb_o,
  output bpt_pkg::bpt_flags_t out_flags_o
);

  // Returns the quotient bit on top and the new remainder below it.
  function automatic logic [NW:0] div_step(input logic [NW-1:0] r,
                                           input logic [NW-1:0] dm);
    logic [NW:0] t;
    logic [NW:0] diff;
    t    = {r, 1'b0};
    diff = t - {1'b0, dm};
    if (t >= {1'b0, dm}) begin
      return {1'b1, diff[NW-1:0]};
    end else begin
      return {1'b0, t[NW-1:0]};
    end
  endfunction

  logic                v_s     [F+1];
  logic [NW-1:0]       ra_s    [F+1];
  logic [NW-1:0]       rb_s    [F+1];
  logic [F:0]          qa_s    [F+1];
  logic [F:0]          qb_s    [F+1];
  bpt_pkg::bpt_flags_t flags_s [F+1];
  logic                rdy     [F+1];

  assign v_s[0]     = in_valid_i;
  assign ra_s[0]    = in_ra_i;
  assign rb_s[0]    = in_rb_i;
  assign qa_s[0]    = {{F{1'b0}}, in_qa_i};
  assign qb_s[0]    = {{F{1'b0}}, in_qb_i};
  assign flags_s[0] = in_flags_i;
  assign rdy[F]     = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < F; k++) begin : g_stage
    logic                v_q;
    logic [NW-1:0]       ra_q;
    logic [NW-1:0]       rb_q;
    logic [F:0]          qa_q;
    logic [F:0]          qb_q;
    bpt_pkg::bpt_flags_t flags_q;
    logic [NW:0]         step_a;
    logic [NW:0]         step_b;

    assign step_a = div_step(ra_s[k], dm_i);
    assign step_b = div_step(rb_s[k], dm_i);
    assign rdy[k] = !v_q || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[k]) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        ra_q    <= step_a[NW-1:0];
        rb_q    <= step_b[NW-1:0];
        qa_q    <= {qa_s[k][F-1:0], step_a[NW]};
        qb_q    <= {qb_s[k][F-1:0], step_b[NW]};
        flags_q <= flags_s[k];
      end
    end

    assign v_s[k+1]     = v_q;
    assign ra_s[k+1]    = ra_q;
    assign rb_s[k+1]    = rb_q;
    assign qa_s[k+1]    = qa_q;
    assign qb_s[k+1]    = qb_q;
    assign flags_s[k+1] = flags_q;
  end

  assign out_valid_o = v_s[F];
  assign out_qa_o    = qa_s[F];
  assign out_qb_o    = qb_s[F];
  assign out_flags_o = flags_s[F];

endmodule
